>>> sv/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU responder.
// No dependencies; every other file imports this package.
`default_nettype none

package mbrtu_pkg;

    // Protocol constants
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  RESET_ADDRESS   = 8'h01;

    // Frame lengths in bytes
    localparam logic [3:0] REQ_LEN   = 4'd8;
    localparam logic [3:0] OTHER_LEN = 4'd13;

    // Register count width (saturation limit never exceeds 125)
    localparam int CNT_W = 7;
    // Wide enough for 2*start + position
    localparam int RD_ADDR_W = 18;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_RX_BYTE   = 2'd0,
        OP_TBL_WRITE = 2'd1,
        OP_PULL      = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    // Accepted request handed from receiver to transmitter
    typedef struct packed {
        logic             load;
        logic [15:0]      start;
        logic [CNT_W-1:0] count;
    } t_req;

    // One response byte
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_tx_res;

    // CRC-16, reflected, one byte (eight shift steps)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/modbus_rtu_read_input_responder_top.sv
// Top level of the Modbus RTU read-input responder: handshakes, item and result registers.
// Depends on mbrtu_pkg, mbrtu_rx, mbrtu_tbl and mbrtu_tx.
//
//   port group  direction  handshake               payload
//   in          to block   i_in_valid/o_in_stall   i_opcode, i_data_byte, i_table_index
//   out         from block o_out_valid/i_out_stall o_tx_byte, o_last_byte
//   cfg         to block   i_cfg_wr_en             i_cfg_wr_data (slave address)
//
// One item per cycle while the output is not stalled: an item is registered at the accepting
// edge and processed once the output register is free; a pull result is loaded into the output
// register at the end of that cycle, so it passes the item register and then the result register.
// The table read is registered and addressed from the sequencer's next position.
// Reset is synchronous; it clears all control state and the table flags.
// A stalled output holds its result; the item register holds until the output frees.
`default_nettype none

module modbus_rtu_read_input_responder_top
    import mbrtu_pkg::*;
#(
    parameter int TABLE_BYTES   = 256,
    parameter int MAX_READ_REGS = 125
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_table_index,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_byte
);

    // Table entries reachable through an 8-bit index
    localparam int DEPTH = (TABLE_BYTES < 256) ? TABLE_BYTES : 256;

    logic [7:0] r_slave_addr;
    logic       r_in_valid;
    t_opcode    r_op;
    logic [7:0] r_data;
    logic [7:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic                 step;
    logic                 in_take;
    t_req                 req;
    t_tx_res              res;
    logic [RD_ADDR_W-1:0] rd_addr;
    logic [7:0]           tbl_byte;

    // Handshake
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // Address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= RESET_ADDRESS;
        end else if (i_cfg_wr_en) begin
            r_slave_addr <= i_cfg_wr_data;
        end
    end

    // Item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_opcode'(i_opcode);
            r_data <= i_data_byte;
            r_idx  <= i_table_index;
        end
    end

    mbrtu_rx #(
        .MAX_READ_REGS(MAX_READ_REGS)
    ) u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step && (r_op == OP_RX_BYTE)),
        .i_byte      (r_data),
        .i_slave_addr(r_slave_addr),
        .o_req       (req)
    );

    mbrtu_tbl #(
        .DEPTH(DEPTH)
    ) u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (step && (r_op == OP_TBL_WRITE)),
        .i_wr_idx (r_idx),
        .i_wr_data(r_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(tbl_byte)
    );

    mbrtu_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pull      (step && (r_op == OP_PULL)),
        .i_req       (req),
        .i_slave_addr(r_slave_addr),
        .i_tbl_byte  (tbl_byte),
        .o_rd_addr   (rd_addr),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_byte <= res.data;
            r_out_last <= res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

`default_nettype wire

>>> sv/mbrtu_rx.sv
// Request receiver: frames serial bytes, checks the CRC, extracts start and count.
// Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_rx
    import mbrtu_pkg::*;
#(
    parameter int MAX_READ_REGS = 125
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_slave_addr,
    output t_req            o_req
);

    logic [3:0]  r_pos, n_pos;
    logic        r_long, n_long;
    logic [15:0] r_crc, n_crc;
    logic [31:0] r_fields, n_fields;

    logic        long_eff;
    logic [15:0] crc_base;
    logic [3:0]  pos_inc;
    logic [15:0] cnt_raw;

    // Next framing state for one received byte
    always_comb begin
        n_pos    = r_pos;
        n_long   = r_long;
        n_crc    = r_crc;
        n_fields = r_fields;
        o_req    = '0;
        long_eff = (r_pos == 4'd0) ? (i_byte != i_slave_addr) : r_long;
        crc_base = (r_pos == 4'd0) ? CRC_INIT : r_crc;
        pos_inc  = r_pos + 4'd1;
        cnt_raw  = r_fields[15:0];

        o_req.start = r_fields[31:16];
        o_req.count = (cnt_raw > 16'(MAX_READ_REGS)) ? CNT_W'(MAX_READ_REGS)
                                                      : cnt_raw[CNT_W-1:0];
        if (i_step) begin
            n_long = long_eff;
            n_crc  = crc_byte(crc_base, i_byte);
            if (long_eff) begin
                n_pos = (pos_inc >= OTHER_LEN) ? 4'd0 : pos_inc;
            end else begin
                if (r_pos >= 4'd2 && r_pos <= 4'd5) begin
                    n_fields = {r_fields[23:0], i_byte};
                end
                if (pos_inc >= REQ_LEN) begin
                    n_pos      = 4'd0;
                    o_req.load = (n_crc == 16'h0000);
                end else begin
                    n_pos = pos_inc;
                end
            end
        end
    end

    // Framing control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 4'd0;
            r_long <= 1'b0;
            r_crc  <= CRC_INIT;
        end else begin
            r_pos  <= n_pos;
            r_long <= n_long;
            r_crc  <= n_crc;
        end
    end

    // Request fields, fully rewritten by every request
    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
    end

endmodule

`default_nettype wire

>>> sv/mbrtu_tbl.sv
// Register table: byte memory with per-entry written flags and a registered read.
// Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_tbl
    import mbrtu_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [7:0]           i_wr_idx,
    input  wire logic [7:0]           i_wr_data,
    input  wire logic [RD_ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_q;
    logic             r_q_vld;
    logic             r_in_range;
    logic             r_byp;
    logic [7:0]       r_byp_data;

    logic wr_ok;
    logic rd_ok;
    logic hit;

    assign wr_ok = i_wr_en && (32'(i_wr_idx) < DEPTH);
    assign rd_ok = (32'(i_rd_addr) < DEPTH);
    assign hit   = wr_ok && rd_ok && (RD_ADDR_W'(i_wr_idx) == i_rd_addr);

    // Storage write
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[AW'(i_wr_idx)] <= i_wr_data;
        end
    end

    // Storage read
    always_ff @(posedge i_clk) begin
        r_q <= mem[AW'(i_rd_addr)];
    end

    // Written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[AW'(i_wr_idx)] <= 1'b1;
        end
    end

    // Flag read and write-to-read forwarding
    always_ff @(posedge i_clk) begin
        r_q_vld    <= r_vld[AW'(i_rd_addr)];
        r_in_range <= rd_ok;
        r_byp      <= hit;
        r_byp_data <= i_wr_data;
    end

    // Out of range or never written reads zero
    always_comb begin
        if (!r_in_range) begin
            o_rd_data = 8'h00;
        end else if (r_byp) begin
            o_rd_data = r_byp_data;
        end else if (r_q_vld) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data = 8'h00;
        end
    end

endmodule

`default_nettype wire

>>> sv/mbrtu_tx.sv
// Response sequencer: emits address, function, byte count, table bytes and CRC.
// Depends on mbrtu_pkg; table data comes from mbrtu_tbl one read ahead.
`default_nettype none

module mbrtu_tx
    import mbrtu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_pull,
    input  wire t_req                 i_req,
    input  wire logic [7:0]           i_slave_addr,
    input  wire logic [7:0]           i_tbl_byte,
    output logic [RD_ADDR_W-1:0]      o_rd_addr,
    output t_tx_res                   o_res
);

    logic             r_pending, n_pending;
    logic [7:0]       r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_start, n_start;
    logic [CNT_W-1:0] r_count, n_count;

    logic [7:0] nbytes;
    logic [8:0] end_pos;
    logic [8:0] pos9;

    // Byte selection and state update for one pull
    always_comb begin
        nbytes    = {r_count, 1'b0};
        end_pos   = {1'b0, nbytes} + 9'd3;
        pos9      = {1'b0, r_pos};
        n_pending = r_pending;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_start   = r_start;
        n_count   = r_count;
        o_res     = '0;

        priority if (pos9 == 9'd0) begin
            o_res.data = i_slave_addr;
        end else if (pos9 == 9'd1) begin
            o_res.data = FUNC_READ_INPUT;
        end else if (pos9 == 9'd2) begin
            o_res.data = nbytes;
        end else if (pos9 < end_pos) begin
            o_res.data = i_tbl_byte;
        end else if (pos9 == end_pos) begin
            o_res.data = r_crc[7:0];
        end else begin
            o_res.data = r_crc[15:8];
            o_res.last = 1'b1;
        end
        o_res.valid = i_pull && r_pending;

        if (i_req.load) begin
            n_pending = 1'b1;
            n_pos     = 8'd0;
            n_crc     = CRC_INIT;
            n_start   = i_req.start;
            n_count   = i_req.count;
        end else if (o_res.valid) begin
            if (pos9 < end_pos) begin
                n_crc = crc_byte(r_crc, o_res.data);
            end
            if (o_res.last) begin
                n_pending = 1'b0;
                n_pos     = 8'd0;
                n_crc     = CRC_INIT;
            end else begin
                n_pos = r_pos + 8'd1;
            end
        end
    end

    // Table address for the byte after this update
    assign o_rd_addr = {1'b0, n_start, 1'b0} + RD_ADDR_W'(n_pos) - RD_ADDR_W'(3);

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_pos     <= 8'd0;
            r_crc     <= CRC_INIT;
            r_start   <= 16'd0;
            r_count   <= '0;
        end else begin
            r_pending <= n_pending;
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_start   <= n_start;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> verif/mbrtu_responder_checker.sv
// Checker for the Modbus RTU read-input responder: follows items and address writes,
// predicts every response byte and compares it with what the block sends.
// Depends on mbrtu_pkg (opcodes, protocol constants); also holds the bench CRC helper.
`timescale 1ns / 1ps

package mbrtu_tb_pkg;
    import mbrtu_pkg::*;

    // CRC-16, reflected polynomial, advanced by one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction
endpackage

module mbrtu_responder_checker
    import mbrtu_pkg::*;
    import mbrtu_tb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_table_index,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_last_byte,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_requests
);

    localparam int TABLE_SIZE   = 256;
    localparam int MAX_REGS     = 125;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_resp;

    // Response bytes owed by the block, oldest first
    t_resp      resp_queue[$];

    // Shadow of the block state
    logic [7:0]  table_copy [TABLE_SIZE];
    logic [7:0]  cur_addr;
    int          rx_pos;
    logic        rx_long;
    logic [15:0] rx_crc;
    logic [31:0] rx_fields;
    logic [15:0] req_start;
    int          req_count;
    logic        tx_busy;
    int          tx_pos;
    logic [15:0] tx_crc;

    int fail_count = 0;
    int checked    = 0;
    int requests   = 0;

    task automatic reset_model();
        foreach (table_copy[k]) table_copy[k] = 8'h00;
        cur_addr  = RESET_ADDRESS;
        rx_pos    = 0;
        rx_long   = 1'b0;
        rx_crc    = CRC_INIT;
        rx_fields = '0;
        req_start = '0;
        req_count = 0;
        tx_busy   = 1'b0;
        tx_pos    = 0;
        tx_crc    = CRC_INIT;
        resp_queue.delete();
    endtask

    // Serial byte into the frame receiver
    task automatic take_rx_byte(input logic [7:0] b);
        logic [15:0] cnt;
        if (rx_pos == 0) begin
            rx_long   = (b != cur_addr);
            rx_crc    = CRC_INIT;
            rx_fields = '0;
        end
        rx_crc = crc16_update(rx_crc, b);
        if (rx_long) begin
            // foreign frame: just count off its 13 bytes
            rx_pos = (rx_pos == 12) ? 0 : rx_pos + 1;
        end else begin
            if (rx_pos >= 2 && rx_pos <= 5) rx_fields = {rx_fields[23:0], b};
            if (rx_pos == 7) begin
                rx_pos = 0;
                if (rx_crc == 16'h0000) begin
                    cnt       = rx_fields[15:0];
                    req_start = rx_fields[31:16];
                    req_count = (cnt > MAX_REGS) ? MAX_REGS : int'(cnt);
                    tx_busy   = 1'b1;
                    tx_pos    = 0;
                    tx_crc    = CRC_INIT;
                    requests++;
                end
            end else begin
                rx_pos++;
            end
        end
    endtask

    // Next byte of the pending response; advances the sender state
    function automatic t_resp next_tx_byte();
        t_resp r;
        int    nbytes;
        int    tbl_idx;
        nbytes      = 2 * req_count;
        r.last_byte = 1'b0;
        if (tx_pos == 0) begin
            r.tx_byte = cur_addr;
        end else if (tx_pos == 1) begin
            r.tx_byte = FUNC_READ_INPUT;
        end else if (tx_pos == 2) begin
            r.tx_byte = nbytes[7:0];
        end else if (tx_pos < 3 + nbytes) begin
            tbl_idx   = 2 * int'(req_start) + tx_pos - 3;
            r.tx_byte = (tbl_idx < TABLE_SIZE) ? table_copy[tbl_idx] : 8'h00;
        end else if (tx_pos == 3 + nbytes) begin
            r.tx_byte = tx_crc[7:0];
        end else begin
            r.tx_byte   = tx_crc[15:8];
            r.last_byte = 1'b1;
        end
        if (tx_pos < 3 + nbytes) tx_crc = crc16_update(tx_crc, r.tx_byte);
        if (r.last_byte) begin
            tx_busy = 1'b0;
            tx_pos  = 0;
            tx_crc  = CRC_INIT;
        end else begin
            tx_pos++;
        end
        return r;
    endfunction

    task automatic apply_item(input t_opcode op, input logic [7:0] data, input logic [7:0] idx);
        case (op)
            OP_RX_BYTE: begin
                take_rx_byte(data);
            end
            OP_TBL_WRITE: begin
                table_copy[idx] = data;
            end
            OP_PULL: begin
                if (tx_busy) resp_queue.push_back(next_tx_byte());
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        t_resp want;
        checked++;
        if (resp_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("ERROR at %0t: unexpected response byte %02h last=%0b",
                         $time, i_tx_byte, i_last_byte);
        end else begin
            want = resp_queue.pop_front();
            if (want.tx_byte !== i_tx_byte || want.last_byte !== i_last_byte) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("ERROR at %0t: byte %0d expected %02h last=%0b, got %02h last=%0b",
                             $time, checked, want.tx_byte, want.last_byte,
                             i_tx_byte, i_last_byte);
            end
        end
    endtask

    // Sample both channels and the address port at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_wr_en) cur_addr = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                apply_item(t_opcode'(i_opcode), i_data_byte, i_table_index);
        end
        o_fail_count <= fail_count;
        o_pending    <= resp_queue.size();
        o_checked    <= checked;
        o_requests   <= requests;
    end

endmodule

>>> verif/modbus_rtu_read_input_responder_top_test.sv
// Testbench top for the Modbus RTU read-input responder: clock, reset, request and
// table stimulus, output stalls and the verdict. Depends on mbrtu_pkg, mbrtu_tb_pkg,
// mbrtu_responder_checker and the block itself.
`timescale 1ns / 1ps

module modbus_rtu_read_input_responder_top_test;
    import mbrtu_pkg::*;
    import mbrtu_tb_pkg::*;

    localparam int ITEMS        = 1650;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid    = 1'b0;
    logic [1:0] opcode      = OP_RX_BYTE;
    logic [7:0] data_byte   = 8'h00;
    logic [7:0] table_index = 8'h00;
    logic       out_stall   = 1'b0;
    wire        in_stall;
    wire        out_valid;
    wire  [7:0] tx_byte;
    wire        last_byte;

    int fail_count;
    int pending;
    int checked;
    int requests;

    // Stimulus-side view of framing and of the response still to pull
    logic [7:0] cur_addr     = RESET_ADDRESS;
    int         rxf_pos      = 0;
    logic       rxf_long     = 1'b0;
    int         tx_left      = 0;
    int         burst_left   = 0;
    int         items_sent   = 0;
    int         table_writes = 0;
    int         cycle_count  = 0;

    // Receiver stall pattern
    int         stall_mode = 0;
    int         stall_left = 0;
    logic [7:0] stall_pat  = 8'h00;

    modbus_rtu_read_input_responder_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_byte   (data_byte),
        .i_table_index (table_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_tx_byte     (tx_byte),
        .o_last_byte   (last_byte)
    );

    mbrtu_responder_checker resp_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_byte   (data_byte),
        .i_table_index (table_index),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_tx_byte     (tx_byte),
        .i_last_byte   (last_byte),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_requests    (requests)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still owed", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: free, light random, heavy random or a rotating pattern, changed now and then
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
            stall_pat  <= 8'($urandom) & 8'hFE;
        end else begin
            stall_left <= stall_left - 1;
            stall_pat  <= {stall_pat[6:0], stall_pat[7]};
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= stall_pat[7];
        endcase
    end

    // One item through the input channel, in bursts with random gaps
    task automatic send_item(input t_opcode op, input logic [7:0] data, input logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= op;
        data_byte   <= data;
        table_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // keep the stimulus view in step
        case (op)
            OP_RX_BYTE: begin
                if (rxf_pos == 0) rxf_long = (data != cur_addr);
                rxf_pos++;
                if (rxf_pos == (rxf_long ? 13 : 8)) rxf_pos = 0;
                items_sent++;
            end
            OP_TBL_WRITE: begin
                table_writes++;
                items_sent++;
            end
            OP_PULL: begin
                if (tx_left > 0) begin
                    tx_left--;
                    items_sent++;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic pull_bytes(input int n);
        repeat (n) send_item(OP_PULL, 8'($urandom), 8'($urandom));
    endtask

    // Finish whatever frame the receiver is in the middle of
    task automatic resync_frame();
        while (rxf_pos != 0) send_item(OP_RX_BYTE, 8'($urandom), 8'($urandom));
    endtask

    // Eight-byte request with its CRC; optionally one bit flipped, optionally other items mixed in
    task automatic send_request(input logic [7:0] a, input logic [7:0] func,
                                input logic [15:0] start, input logic [15:0] count,
                                input logic corrupt, input logic mix);
        logic [7:0]  fb [8];
        logic [15:0] crc;
        int          flip;
        fb[0] = a;
        fb[1] = func;
        fb[2] = start[15:8];
        fb[3] = start[7:0];
        fb[4] = count[15:8];
        fb[5] = count[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) crc = crc16_update(crc, fb[k]);
        fb[6] = crc[7:0];
        fb[7] = crc[15:8];
        if (corrupt) begin
            flip = $urandom_range(0, 63);
            fb[flip / 8][flip % 8] = ~fb[flip / 8][flip % 8];
        end
        resync_frame();
        for (int k = 0; k < 8; k++) begin
            if (mix && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0:       send_item(OP_TBL_WRITE, 8'($urandom), 8'($urandom));
                    1:       send_item(OP_PULL, 8'($urandom), 8'($urandom));
                    default: send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
                endcase
            end
            send_item(OP_RX_BYTE, fb[k], 8'($urandom));
        end
        if (!corrupt && a == cur_addr)
            tx_left = 5 + 2 * ((count > 16'd125) ? 125 : int'(count));
    endtask

    // Mostly short reads inside the table, a few saturating or past the end
    task automatic random_request(input logic corrupt);
        logic [15:0] start;
        logic [15:0] count;
        logic [7:0]  func;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)       count = 16'($urandom_range(126, 65535));
        else if (sel < 6)  count = 16'd125;
        else if (sel < 10) count = 16'd0;
        else               count = 16'($urandom_range(1, 6));
        sel = $urandom_range(0, 9);
        if (sel < 7)      start = 16'($urandom_range(0, 127));
        else if (sel < 9) start = 16'($urandom_range(120, 140));
        else              start = 16'($urandom);
        func = ($urandom_range(0, 4) == 0) ? 8'($urandom) : FUNC_READ_INPUT;
        send_request(cur_addr, func, start, count, corrupt, $urandom_range(0, 3) == 0);
    endtask

    // Let every owed byte arrive, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_address(input logic [7:0] v);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_addr   = v;
        burst_left = 0;
    endtask

    initial begin
        logic [7:0] addr_plan [PHASES];
        logic [7:0] first;
        int         phase_end;
        int         sel;

        addr_plan = '{RESET_ADDRESS, 8'h00, 8'hFF, 8'($urandom_range(2, 254)), RESET_ADDRESS};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: table edges, idle pull, unused opcode, function code not checked
        send_item(OP_TBL_WRITE, 8'hFF, 8'hFF);
        send_item(OP_TBL_WRITE, 8'h5A, 8'hFE);
        send_item(OP_TBL_WRITE, 8'hA5, 8'h00);
        send_item(OP_PULL, 8'h00, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        send_request(cur_addr, 8'h03, 16'd127, 16'd1, 1'b0, 1'b0);
        pull_bytes(tx_left);

        // Random phases, one per slave address
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) set_address(addr_plan[phase]);
            phase_end = items_sent + ITEMS / PHASES;
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    // good request, mostly read out in full, sometimes cut short
                    random_request(1'b0);
                    if ($urandom_range(0, 4) == 0) pull_bytes($urandom_range(0, tx_left));
                    else pull_bytes(tx_left);
                end else if (sel < 60) begin
                    random_request(1'b1);
                end else if (sel < 68) begin
                    // frame for another station
                    resync_frame();
                    first = 8'($urandom);
                    while (first == cur_addr) first = 8'($urandom);
                    send_item(OP_RX_BYTE, first, 8'($urandom));
                    repeat (12) send_item(OP_RX_BYTE, 8'($urandom), 8'($urandom));
                end else if (sel < 78) begin
                    repeat ($urandom_range(1, 6))
                        send_item(OP_TBL_WRITE, 8'($urandom), 8'($urandom));
                end else if (sel < 90) begin
                    // line noise and stray items
                    repeat ($urandom_range(1, 4))
                        send_item(t_opcode'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                end else begin
                    pull_bytes($urandom_range(1, 4));
                end
            end
        end

        wait_idle();
        $display("Run covered %0d items under %0d slave addresses: %0d table writes, %0d requests",
                 items_sent, PHASES, table_writes, requests);
        $display("answered, %0d response bytes compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
